/* design/spwm_pkg.sv */
// Shared constants, types and the quarter-wave sine table of the sine PWM generator.
// No dependencies; every other design file but spwm_checker imports this package.
package spwm_pkg;

  localparam int SINE_TABLE_SIZE = 256;
  localparam int IDX_W           = $clog2(SINE_TABLE_SIZE);
  localparam int LEVEL_WIDTH     = 16;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [31:0] OFFSET_120  = 32'h5555_5555;
  localparam logic [31:0] OFFSET_180  = 32'h8000_0000;
  localparam logic [31:0] OFFSET_M120 = 32'hAAAA_AAAB;   // minus 120 degrees
  localparam logic signed [17:0] DUTY_HALF = 18'sd16384;
  localparam logic signed [17:0] DUTY_ONE  = 18'sd32768;

  // operating mode codes
  localparam logic [1:0] MODE_DUTY  = 2'd0;
  localparam logic [1:0] MODE_ANGLE = 2'd1;
  localparam logic [1:0] MODE_SPEED = 2'd2;

  // opcode codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PRIME = 1'b1;

  // register indexes
  localparam logic [2:0] REG_OP_MODE       = 3'd0;
  localparam logic [2:0] REG_PHASE_COUNT   = 3'd1;
  localparam logic [2:0] REG_MOD_DEPTH     = 3'd2;
  localparam logic [2:0] REG_DUTY_FLOOR    = 3'd3;
  localparam logic [2:0] REG_PERIOD_COUNT  = 3'd4;
  localparam logic [2:0] REG_DEADTIME_LOW  = 3'd5;
  localparam logic [2:0] REG_DEADTIME_HIGH = 3'd6;
  localparam logic [2:0] REG_BURST_CYCLES  = 3'd7;

  typedef struct packed {
    logic [1:0]  op_mode;
    logic [1:0]  phase_count;
    logic [15:0] mod_depth;
    logic [14:0] duty_floor;
    logic [15:0] period_count;
    logic [15:0] deadtime_low_side;
    logic [15:0] deadtime_high_side;
    logic [31:0] burst_cycles;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic        running;
    logic        reload;
    logic [2:0][15:0] duty;
    logic [31:0] start_angle;
    logic [31:0] speed_step;
    logic        burst_limited;
  } item_in_t;

  typedef struct packed {
    logic        aborted;
    logic [2:0][15:0] level_low;
    logic [2:0][15:0] level_high;
  } item_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       pre;
    logic       rom;
    logic       interp;
    logic       modul;
    logic       clip;
    logic       scale;
    logic       write;
    logic       commit;
    logic       emit;
    logic [1:0] phase;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic abort;
  } stat_t;

  typedef logic [15:0] rom_t [0:SINE_TABLE_SIZE];

  // Q30 Taylor series of sin, evaluated at elaboration.
  function automatic rom_t build_rom();
    rom_t t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic signed [63:0] r;
    for (int i = 0; i <= SINE_TABLE_SIZE; i++) begin
      x = (64'(i) * HALF_PI_Q30 + 64'(SINE_TABLE_SIZE / 2)) / SINE_TABLE_SIZE;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2 + (64'd1 << 29)) >> 30;
        case (k)
          1: term = (term + 64'd3) / 64'd6;
          2: term = (term + 64'd10) / 64'd20;
          3: term = (term + 64'd21) / 64'd42;
          4: term = (term + 64'd36) / 64'd72;
          5: term = (term + 64'd55) / 64'd110;
          6: term = (term + 64'd78) / 64'd156;
          7: term = (term + 64'd105) / 64'd210;
          default: term = (term + 64'd136) / 64'd272;
        endcase
        if ((k % 2) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32768) r = 64'sd32768;
      t[i] = r[15:0];
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

/* design/spwm_regs.sv */
// APB configuration registers of the sine PWM generator.
// Depends on spwm_pkg for register indexes and the cfg_t bundle.
module spwm_regs
  import spwm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_OP_MODE:       cfg_d.op_mode            = pwdata[1:0];
        REG_PHASE_COUNT:   cfg_d.phase_count        = pwdata[1:0];
        REG_MOD_DEPTH:     cfg_d.mod_depth          = pwdata[15:0];
        REG_DUTY_FLOOR:    cfg_d.duty_floor         = pwdata[14:0];
        REG_PERIOD_COUNT:  cfg_d.period_count       = pwdata[15:0];
        REG_DEADTIME_LOW:  cfg_d.deadtime_low_side  = pwdata[15:0];
        REG_DEADTIME_HIGH: cfg_d.deadtime_high_side = pwdata[15:0];
        default:           cfg_d.burst_cycles       = pwdata;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OP_MODE:       prdata = {30'd0, cfg_q.op_mode};
      REG_PHASE_COUNT:   prdata = {30'd0, cfg_q.phase_count};
      REG_MOD_DEPTH:     prdata = {16'd0, cfg_q.mod_depth};
      REG_DUTY_FLOOR:    prdata = {17'd0, cfg_q.duty_floor};
      REG_PERIOD_COUNT:  prdata = {16'd0, cfg_q.period_count};
      REG_DEADTIME_LOW:  prdata = {16'd0, cfg_q.deadtime_low_side};
      REG_DEADTIME_HIGH: prdata = {16'd0, cfg_q.deadtime_high_side};
      default:           prdata = cfg_q.burst_cycles;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_mode            <= MODE_DUTY;
      cfg_q.phase_count        <= 2'd3;
      cfg_q.mod_depth          <= 16'd32768;
      cfg_q.duty_floor         <= 15'd0;
      cfg_q.period_count       <= 16'd65535;
      cfg_q.deadtime_low_side  <= 16'd0;
      cfg_q.deadtime_high_side <= 16'd0;
      cfg_q.burst_cycles       <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/spwm_ctrl.sv */
// Sequencer of the sine PWM generator: handshakes and per-phase step commands.
// Depends on spwm_pkg for cmd_t and stat_t.
module spwm_ctrl
  import spwm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PRE    = 4'd1;
  localparam logic [3:0] S_ROM    = 4'd2;
  localparam logic [3:0] S_INTERP = 4'd3;
  localparam logic [3:0] S_MOD    = 4'd4;
  localparam logic [3:0] S_CLIP   = 4'd5;
  localparam logic [3:0] S_SCALE  = 4'd6;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic       ovalid_q, ovalid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign slot_free   = !ovalid_q || out_ready_i;

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.phase = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PRE;
        end
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        phase_d   = 2'd0;
        state_d   = stat_i.abort ? S_DONE : S_ROM;
      end
      S_ROM: begin
        cmd_o.rom = 1'b1;
        state_d   = S_INTERP;
      end
      S_INTERP: begin
        cmd_o.interp = 1'b1;
        state_d      = S_MOD;
      end
      S_MOD: begin
        cmd_o.modul = 1'b1;
        state_d     = S_CLIP;
      end
      S_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        if (phase_q == 2'd2) begin
          cmd_o.commit = 1'b1;
          state_d      = S_DONE;
        end else begin
          phase_d = phase_q + 2'd1;
          state_d = S_ROM;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.emit = 1'b1;
          ovalid_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

/* design/spwm_dp.sv */
// Datapath of the sine PWM generator: phase accumulator, sine lookup,
// modulation, clipping, scaling and deadtime. Depends on spwm_pkg.
module spwm_dp
  import spwm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  item_in_t  item_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output item_out_t item_o
);

  item_in_t in_q;

  logic [31:0] acc_q, step_q, count_q, limit_q;
  logic [2:0][15:0] held_q;

  logic [15:0] a_q, b_q;
  logic [29:0] frac_q;
  logic        neg_q;
  logic [15:0] val_q;
  logic signed [17:0] duty_q;
  logic [15:0] dclip_q;
  logic [31:0] prod_q;

  logic        abt_q;
  logic [2:0][15:0] lo_q, hi_q;
  item_out_t   out_q;

  // abort check
  logic [31:0] cnt_inc;
  logic        is_tick, stop;
  assign cnt_inc = count_q + 32'd1;
  assign is_tick = (in_q.opcode == OP_TICK);
  assign stop    = in_q.burst_limited && (cnt_inc >= limit_q);
  assign stat_o.abort = is_tick && (stop || !in_q.running);

  // phase and table lookup
  logic [31:0]      ph_off, ph;
  logic [IDX_W-1:0] idx, fidx;
  logic [IDX_W:0]   addr_a, addr_b;
  always_comb begin
    case (cmd_i.phase)
      2'd0:    ph_off = 32'd0;
      2'd1:    ph_off = (cfg_i.phase_count == 2'd2) ? OFFSET_180 : OFFSET_120;
      default: ph_off = OFFSET_M120;
    endcase
    ph   = acc_q + ph_off;
    idx  = ph[29 -: IDX_W];
    fidx = ~idx;
    if (ph[30]) begin
      addr_a = {1'b0, fidx} + 1'b1;
      addr_b = {1'b0, fidx};
    end else begin
      addr_a = {1'b0, idx};
      addr_b = {1'b0, idx} + 1'b1;
    end
  end

  // interpolation
  logic        up;
  logic [15:0] diff;
  logic [46:0] iprod;
  logic [15:0] adj;
  assign up    = (b_q >= a_q);
  assign diff  = up ? (b_q - a_q) : (a_q - b_q);
  assign iprod = 47'(diff * frac_q) + (47'd1 << 29);
  assign adj   = iprod[45:30];

  // modulation and source select
  logic [32:0] mprod;
  logic signed [17:0] sine_duty, src;
  logic use_sine, half;
  always_comb begin
    mprod     = 33'(cfg_i.mod_depth * val_q) + 33'd32768;
    sine_duty = neg_q ? DUTY_HALF - $signed({1'b0, mprod[32:16]})
                      : DUTY_HALF + $signed({1'b0, mprod[32:16]});
    use_sine  = (cfg_i.op_mode != MODE_DUTY) &&
                ((cfg_i.phase_count == 2'd3) ||
                 ((cfg_i.phase_count == 2'd2) && (cmd_i.phase != 2'd2)));
    half      = (cfg_i.op_mode != MODE_DUTY) && (cfg_i.phase_count < 2'd2);
    if (use_sine) src = sine_duty;
    else if (half) src = DUTY_HALF;
    else if ((cfg_i.op_mode == MODE_DUTY) && in_q.reload)
      src = $signed({2'b00, in_q.duty[cmd_i.phase]});
    else src = $signed({2'b00, held_q[cmd_i.phase]});
  end

  // clip
  logic active;
  logic signed [17:0] lo_b, hi_b, d1, d2;
  always_comb begin
    active = ({1'b0, cmd_i.phase} < {1'b0, cfg_i.phase_count});
    lo_b   = $signed({3'b000, cfg_i.duty_floor});
    hi_b   = DUTY_ONE - lo_b;
    d1     = (duty_q < lo_b) ? lo_b : duty_q;
    d2     = (d1 > hi_b) ? hi_b : d1;
  end

  // level with deadtime
  logic [LEVEL_WIDTH-1:0] level, lvl_lo, lvl_hi;
  assign level  = prod_q[15 +: LEVEL_WIDTH];
  assign lvl_lo = level - cfg_i.deadtime_low_side[LEVEL_WIDTH-1:0];
  assign lvl_hi = level + cfg_i.deadtime_high_side[LEVEL_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= item_i;
    if (cmd_i.pre) begin
      abt_q <= stat_o.abort;
      lo_q  <= '0;
      hi_q  <= '0;
    end
    if (cmd_i.rom) begin
      a_q    <= SINE_ROM[addr_a];
      b_q    <= SINE_ROM[addr_b];
      frac_q <= {ph[29-IDX_W:0], {IDX_W{1'b0}}};
      neg_q  <= ph[31];
    end
    if (cmd_i.interp) val_q <= up ? (a_q + adj) : (a_q - adj);
    if (cmd_i.modul) duty_q <= src;
    if (cmd_i.clip) dclip_q <= active ? d2[15:0] : duty_q[15:0];
    if (cmd_i.scale) prod_q <= dclip_q * cfg_i.period_count;
    if (cmd_i.write && active) begin
      lo_q[cmd_i.phase] <= 16'(lvl_lo);
      hi_q[cmd_i.phase] <= 16'(lvl_hi);
    end
    if (cmd_i.emit) begin
      out_q.aborted    <= abt_q;
      out_q.level_low  <= lo_q;
      out_q.level_high <= hi_q;
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 32'd0;
      step_q  <= 32'd0;
      count_q <= 32'd0;
      limit_q <= 32'd0;
      held_q  <= {3{16'd16384}};
    end else begin
      if (cmd_i.pre) begin
        if (is_tick && in_q.burst_limited) count_q <= cnt_inc;
        if (!stat_o.abort) begin
          if ((cfg_i.op_mode == MODE_ANGLE) && in_q.reload) begin
            acc_q <= in_q.start_angle;
          end else if (cfg_i.op_mode == MODE_SPEED) begin
            if (in_q.reload) begin
              step_q <= in_q.speed_step;
              acc_q  <= acc_q + in_q.speed_step;
            end else begin
              acc_q <= acc_q + step_q;
            end
          end
        end
      end
      if (cmd_i.write) held_q[cmd_i.phase] <= dclip_q;
      if (cmd_i.commit && (in_q.opcode == OP_PRIME)) begin
        acc_q   <= 32'd0;
        count_q <= 32'd0;
        limit_q <= cfg_i.burst_cycles;
      end
    end
  end

  assign item_o = out_q;

endmodule

/* design/sine_pwm_phase_duty_generator.sv */
// Top level of the three-phase sine PWM compare-level generator.
// Depends on spwm_pkg, spwm_regs, spwm_ctrl and spwm_dp.
//
// One input item per PWM wrap tick (or prime) gives one output item with
// low- and high-side compare levels for up to three phases. After acceptance,
// one step handles the accumulator and the burst check; an aborted tick then
// goes straight to loading the output register. Otherwise six steps per phase
// run through a single shared lookup/multiply datapath for all three phases,
// then the output register is loaded. The next item is taken while a result
// waits in the output register. The sine comes from a 257-entry quarter-wave
// table with linear interpolation; offsets are 180 degrees for two phases and
// +/-120 degrees for three. Levels wrap modulo 2^16 after deadtime. The user
// must write configuration over APB while the block is idle; the block does
// not enforce this. Registers lie at byte address 4*i.
module sine_pwm_phase_duty_generator
  import spwm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // running[0], reload[1], duty_first[17:2], duty_second[33:18],
  // duty_third[49:34], start_angle[81:50], speed_step[113:82],
  // burst_limited[114], zero[119:115]
  input  logic [119:0] s_axis_tdata_i,
  input  logic         s_axis_tuser_i,   // opcode
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // level_low_first[15:0], level_high_first[31:16], level_low_second[47:32],
  // level_high_second[63:48], level_low_third[79:64], level_high_third[95:80]
  output logic [95:0]  m_axis_tdata_o,
  output logic         m_axis_tuser_o,   // aborted
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t      cfg;
  item_in_t  item_in;
  item_out_t item_out;
  cmd_t      cmd;
  stat_t     stat;

  always_comb begin
    item_in.opcode        = s_axis_tuser_i;
    item_in.running       = s_axis_tdata_i[0];
    item_in.reload        = s_axis_tdata_i[1];
    item_in.duty[0]       = s_axis_tdata_i[17:2];
    item_in.duty[1]       = s_axis_tdata_i[33:18];
    item_in.duty[2]       = s_axis_tdata_i[49:34];
    item_in.start_angle   = s_axis_tdata_i[81:50];
    item_in.speed_step    = s_axis_tdata_i[113:82];
    item_in.burst_limited = s_axis_tdata_i[114];
  end

  assign m_axis_tuser_o = item_out.aborted;
  assign m_axis_tdata_o = {item_out.level_high[2], item_out.level_low[2],
                           item_out.level_high[1], item_out.level_low[1],
                           item_out.level_high[0], item_out.level_low[0]};

  spwm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spwm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spwm_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .item_i (item_in),
    .cmd_i  (cmd),
    .stat_o (stat),
    .item_o (item_out)
  );

endmodule

/* design/spwm_checker.sv */
// Port-level checks for the sine PWM generator, bound to the top level.
// Depends only on the top level's ports.
module spwm_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic [119:0] s_axis_tdata_i,
  input logic         s_axis_tuser_i,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic [95:0]  m_axis_tdata_o,
  input logic         m_axis_tuser_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [4:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  // aborted items carry no levels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 96'd0))
    else $error("aborted item with nonzero levels");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("accepted a second item while busy");

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sine_pwm_phase_duty_generator spwm_checker u_spwm_checker (.*);
